// ----- src/curve_normal_window_partition_defines.svh -----
// assertion macros shared by the curve normal window partition rtl
`ifndef CURVE_NORMAL_WINDOW_PARTITION_DEFINES_SVH
`define CURVE_NORMAL_WINDOW_PARTITION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CNWP_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CNWP_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/cnwp_pkg.sv -----
// shared types, constants and register codes of the curve window partitioner
`default_nettype none
package cnwp_pkg;

  localparam int MAX_POINTS_DEF  = 1024;
  localparam int MAX_WINDOWS_DEF = 64;

  localparam int COMP_W     = 16;
  localparam int LEN_W      = 32;
  localparam int RANGE_W    = 10;
  localparam int FRAMES_W   = 7;
  localparam int LIMIT_W    = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int DOT_W      = 34;

  // 0.9 cluster bound: dot * 10 > 9 * 2^30
  localparam longint NEAR_LIM = 64'sd9663676416;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_COS   = 3'd0,
    REG_BREAK_COS  = 3'd1,
    REG_MIN_LENGTH = 3'd2,
    REG_MAX_FRAMES = 3'd3,
    REG_HAVE_LEN   = 3'd4
  } cfg_reg_t;

  localparam logic signed [COMP_W-1:0] TURN_COS_RST  = 16'sd28378;
  localparam logic signed [COMP_W-1:0] BREAK_COS_RST = 16'sd16384;
  localparam logic [LEN_W-1:0]         MIN_LEN_RST   = '0;
  localparam logic [FRAMES_W-1:0]      FRAMES_RST    = 7'd8;
  localparam logic                     HAVE_LEN_RST  = 1'b1;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  typedef struct packed {
    logic  done;
    comp_t x;
    comp_t y;
    comp_t z;
  } norm_res_t;

endpackage
`default_nettype wire

// ----- src/curve_normal_window_partition.sv -----
// top level: sample loading, window search and per-window result sequencing
//
// usage
//   samples arrive on the command channel: a request is taken at a clock edge
//   with start high and busy low. a request without last_point is written to
//   the sample memories and busy stays low, so one sample per cycle loads.
//   samples past MAX_POINTS are dropped and mark the curve capped.
//   a request with last_point ends the curve: busy rises and the block first
//   walks the stored samples to find window bounds (states A_TEST, A_RD and
//   A_CMP per sample visited, one memory read at a time), writing them to a
//   window memory. it then revisits every window to form its dominant normal:
//   a pass over its samples (B_ADDR, B_RD, B_ACC each), rescaling, a serial
//   square root and three serial divides.
//   each window result shows on the result ports for one cycle with
//   result_valid high; the receiver cannot hold results off. last_range
//   marks the final one, and busy falls the cycle after it.
//   a curve of fewer than two samples gives one result with ok low, the cycle
//   after its last request. the user writes configuration through
//   cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
//   reset (synchronous) empties the curve and restores register defaults;
//   the sample memories need no clearing since only written entries are read.
`default_nettype none
`include "curve_normal_window_partition_defines.svh"
module curve_normal_window_partition import cnwp_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // command channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic signed [COMP_W-1:0] normal_x,
  input  wire logic signed [COMP_W-1:0] normal_y,
  input  wire logic signed [COMP_W-1:0] normal_z,
  input  wire logic [LEN_W-1:0]      arc_length,
  input  wire logic                  last_point,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // results
  output logic                       result_valid,
  output logic [RANGE_W-1:0]         range_start,
  output logic [RANGE_W-1:0]         range_end,
  output logic signed [COMP_W-1:0]   dom_x,
  output logic signed [COMP_W-1:0]   dom_y,
  output logic signed [COMP_W-1:0]   dom_z,
  output logic                       capped,
  output logic                       ok,
  output logic                       last_range
);

  localparam int PW  = $clog2(MAX_POINTS);
  localparam int CW  = PW + 1;
  localparam int WAW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int WCW = $clog2(MAX_WINDOWS + 1);
  localparam int SW  = PW + COMP_W + 1;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    A_SEED    = 16'h0002,
    A_SEEDW   = 16'h0004,
    A_TEST    = 16'h0008,
    A_RD      = 16'h0010,
    A_CMP     = 16'h0020,
    A_CLOSE   = 16'h0040,
    B_START   = 16'h0080,
    B_WW      = 16'h0100,
    B_SEED    = 16'h0200,
    B_SEEDW   = 16'h0400,
    B_ADDR    = 16'h0800,
    B_RD      = 16'h1000,
    B_ACC     = 16'h2000,
    B_NORM    = 16'h4000,
    B_WAITN   = 16'h8000
  } state_t;

  state_t state;

  // configuration registers
  logic signed [COMP_W-1:0] turn_thr, break_thr;
  logic [LEN_W-1:0]         min_span;
  logic [FRAMES_W-1:0]      frame_cap;
  logic                     len_valid;

  // curve bookkeeping
  logic [CW-1:0]  point_count, pc_eff, cnt, last_idx;
  logic           overflow_flag, ovf_r, full;
  logic [PW-1:0]  bgn, endp, idx, end_f, mid_sel;
  logic [CW-1:0]  mid;
  logic [WCW-1:0] nwin, widx;
  logic           capped_r, hard_r, cap_now;
  logic [LIMIT_W-1:0] limit;

  // sample memories and window memory
  logic           accept, st_we;
  logic [PW-1:0]  n_raddr;
  vec_t           in_vec, nrd, seed, cur;
  logic [LEN_W-1:0] lrd, seed_len, len_e;
  logic           win_we;
  logic [2*PW-1:0] win_wdata, wrd;

  // dot and cluster sums
  logic signed [DOT_W-1:0]   dot_v;
  logic signed [30:0]        bc31, tc31;
  logic signed [LEN_W+1:0]   len_d;
  logic signed [DOT_W+3:0]   d_ext, d10;
  logic                      brk_hard, brk_turn, is_near;
  logic signed [SW-1:0]      near_x, near_y, near_z, far_x, far_y, far_z;
  logic [CW-1:0]             cn, cf;
  logic                      use_near;
  norm_res_t                 nres;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE) || result_valid;
  assign full   = (point_count == CW'(MAX_POINTS));
  assign pc_eff = full ? point_count : point_count + CW'(1);
  assign st_we  = accept && !full;
  assign in_vec = '{x: normal_x, y: normal_y, z: normal_z};

  always_comb begin
    case (state)
      A_TEST:  n_raddr = endp;
      B_ADDR:  n_raddr = idx;
      default: n_raddr = bgn;
    endcase
  end

  cnwp_ram #(.WIDTH($bits(vec_t)), .DEPTH(MAX_POINTS)) u_normal_ram (
    .clk(clk), .we(st_we), .waddr(point_count[PW-1:0]), .wdata(in_vec),
    .raddr(n_raddr), .rdata(nrd)
  );

  cnwp_ram #(.WIDTH(LEN_W), .DEPTH(MAX_POINTS)) u_length_ram (
    .clk(clk), .we(st_we), .waddr(point_count[PW-1:0]), .wdata(arc_length),
    .raddr(n_raddr), .rdata(lrd)
  );

  cnwp_ram #(.WIDTH(2*PW), .DEPTH(MAX_WINDOWS)) u_window_ram (
    .clk(clk), .we(win_we), .waddr(nwin[WAW-1:0]), .wdata(win_wdata),
    .raddr(widx[WAW-1:0]), .rdata(wrd)
  );

  // dot of the sample just read against the window seed
  cnwp_dot u_dot (.clk(clk), .a(nrd), .b(seed), .dot(dot_v));

  // break tests: cosines scaled to q1.30, length covered since the seed
  assign bc31     = {break_thr, 15'b0};
  assign tc31     = {turn_thr, 15'b0};
  assign len_d    = len_valid ? $signed({2'b0, len_e}) - $signed({2'b0, seed_len}) : '0;
  assign brk_hard = dot_v < bc31;
  assign brk_turn = (dot_v < tc31) && (len_d >= $signed({2'b0, min_span}));

  // 0.9 cluster membership
  assign d_ext   = (DOT_W+4)'(dot_v);
  assign d10     = (d_ext <<< 3) + (d_ext <<< 1);
  assign is_near = d10 > NEAR_LIM;

  // window close: limit on window count, forced stretch to the curve end
  assign last_idx  = cnt - CW'(1);
  assign limit     = ({1'b0, frame_cap} > LIMIT_W'(MAX_WINDOWS))
                     ? LIMIT_W'(MAX_WINDOWS) : {1'b0, frame_cap};
  assign cap_now   = (LIMIT_W'(nwin) + LIMIT_W'(1) >= limit) && ({1'b0, endp} < last_idx);
  assign end_f     = cap_now ? last_idx[PW-1:0] : endp;
  assign win_we    = (state == A_CLOSE);
  assign win_wdata = {bgn, end_f};

  // half-overlap restart point after a gradual turn
  assign mid     = ({1'b0, bgn} + {1'b0, endp}) >> 1;
  assign mid_sel = (mid > {1'b0, bgn} + CW'(1)) ? mid[PW-1:0] : bgn + PW'(1);

  assign use_near = cn >= cf;

  cnwp_norm #(.SW(SW)) u_norm (
    .clk(clk), .rst(rst), .start(state == B_NORM),
    .sum_x(use_near ? near_x : far_x),
    .sum_y(use_near ? near_y : far_y),
    .sum_z(use_near ? near_z : far_z),
    .seed(seed), .res(nres)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_thr  <= TURN_COS_RST;
      break_thr <= BREAK_COS_RST;
      min_span  <= MIN_LEN_RST;
      frame_cap <= FRAMES_RST;
      len_valid <= HAVE_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TURN_COS:   turn_thr  <= cfg_data[COMP_W-1:0];
        REG_BREAK_COS:  break_thr <= cfg_data[COMP_W-1:0];
        REG_MIN_LENGTH: min_span  <= cfg_data[LEN_W-1:0];
        REG_MAX_FRAMES: frame_cap <= cfg_data[FRAMES_W-1:0];
        REG_HAVE_LEN:   len_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      point_count   <= '0;
      overflow_flag <= 1'b0;
      result_valid  <= 1'b0;
      nwin          <= '0;
      widx          <= '0;
      capped_r      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (last_point) begin
              cnt           <= pc_eff;
              ovf_r         <= overflow_flag || full;
              point_count   <= '0;
              overflow_flag <= 1'b0;
              nwin          <= '0;
              widx          <= '0;
              capped_r      <= 1'b0;
              bgn           <= '0;
              if (pc_eff < CW'(2)) begin
                // curve too short: one failure result
                result_valid <= 1'b1;
                range_start  <= '0;
                range_end    <= '0;
                dom_x        <= '0;
                dom_y        <= '0;
                dom_z        <= '0;
                capped       <= overflow_flag || full;
                ok           <= 1'b0;
                last_range   <= 1'b1;
              end else begin
                state <= A_SEED;
              end
            end else begin
              point_count   <= pc_eff;
              overflow_flag <= overflow_flag || full;
            end
          end
        end
        // window search
        A_SEED: state <= A_SEEDW;
        A_SEEDW: begin
          seed     <= nrd;
          seed_len <= lrd;
          endp     <= bgn + PW'(1);
          state    <= A_TEST;
        end
        A_TEST: begin
          state <= ({1'b0, endp} < last_idx) ? A_RD : A_CLOSE;
        end
        A_RD: begin
          len_e <= lrd;
          state <= A_CMP;
        end
        A_CMP: begin
          hard_r <= brk_hard;
          if (brk_hard || brk_turn) begin
            state <= A_CLOSE;
          end else begin
            endp  <= endp + PW'(1);
            state <= A_TEST;
          end
        end
        A_CLOSE: begin
          nwin <= nwin + WCW'(1);
          if (cap_now) capped_r <= 1'b1;
          if ({1'b0, end_f} >= last_idx) begin
            state <= B_START;
          end else begin
            bgn   <= hard_r ? endp : mid_sel;
            state <= A_SEED;
          end
        end
        // per-window dominant normal and result
        B_START: state <= B_WW;
        B_WW: begin
          bgn   <= wrd[2*PW-1:PW];
          endp  <= wrd[PW-1:0];
          state <= B_SEED;
        end
        B_SEED: state <= B_SEEDW;
        B_SEEDW: begin
          seed   <= nrd;
          idx    <= bgn;
          near_x <= '0;
          near_y <= '0;
          near_z <= '0;
          far_x  <= '0;
          far_y  <= '0;
          far_z  <= '0;
          cn     <= '0;
          cf     <= '0;
          state  <= B_ADDR;
        end
        B_ADDR: state <= B_RD;
        B_RD: begin
          cur   <= nrd;
          state <= B_ACC;
        end
        B_ACC: begin
          if (is_near) begin
            near_x <= near_x + SW'(cur.x);
            near_y <= near_y + SW'(cur.y);
            near_z <= near_z + SW'(cur.z);
            cn     <= cn + CW'(1);
          end else begin
            far_x <= far_x + SW'(cur.x);
            far_y <= far_y + SW'(cur.y);
            far_z <= far_z + SW'(cur.z);
            cf    <= cf + CW'(1);
          end
          if (idx == endp) begin
            state <= B_NORM;
          end else begin
            idx   <= idx + PW'(1);
            state <= B_ADDR;
          end
        end
        B_NORM: state <= B_WAITN;
        B_WAITN: begin
          if (nres.done) begin
            result_valid <= 1'b1;
            range_start  <= RANGE_W'(bgn);
            range_end    <= RANGE_W'(endp);
            dom_x        <= nres.x;
            dom_y        <= nres.y;
            dom_z        <= nres.z;
            capped       <= capped_r || ovf_r;
            ok           <= 1'b1;
            last_range   <= (widx + WCW'(1) == nwin);
            if (widx + WCW'(1) == nwin) begin
              state <= S_IDLE;
            end else begin
              widx  <= widx + WCW'(1);
              state <= B_START;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CNWP_IMPLY(a_fail_is_last, result_valid && !ok, last_range, "failure result not marked last")
  `CNWP_IMPLY(a_window_order, win_we, bgn < end_f, "window closed before its seed")
  `CNWP_NEXT(a_quiet_after_last, result_valid && last_range, !result_valid, "result after last")
  `CNWP_NEXT(a_no_mid_result, accept && !last_point, !result_valid, "result on a non-final request")

endmodule
`default_nettype wire

// ----- src/cnwp_ram.sv -----
// generic simple dual port ram with registered read
`default_nettype none
module cnwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/cnwp_dot.sv -----
// registered three-term dot product of two q1.15 normals
`default_nettype none
module cnwp_dot import cnwp_pkg::*; (
  input  wire logic                     clk,
  input  wire vec_t                     a,
  input  wire vec_t                     b,
  output logic signed [DOT_W-1:0]       dot
);

  logic signed [2*COMP_W-1:0] p0, p1, p2;

  always_ff @(posedge clk) begin
    p0 <= a.x * b.x;
    p1 <= a.y * b.y;
    p2 <= a.z * b.z;
  end

  assign dot = DOT_W'(p0) + DOT_W'(p1) + DOT_W'(p2);

endmodule
`default_nettype wire

// ----- src/cnwp_norm.sv -----
// dominant normal unit: rescale, square sum, bit-serial sqrt and divide
`default_nettype none
module cnwp_norm import cnwp_pkg::*; #(
  parameter int SW = 27
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [SW-1:0] sum_x,
  input  wire logic signed [SW-1:0] sum_y,
  input  wire logic signed [SW-1:0] sum_z,
  input  wire vec_t                 seed,
  output norm_res_t                 res
);

  typedef enum logic [7:0] {
    N_IDLE   = 8'b0000_0001,
    N_SCALE  = 8'b0000_0010,
    N_SQ     = 8'b0000_0100,
    N_SUMQ   = 8'b0000_1000,
    N_SQRT   = 8'b0001_0000,
    N_DIVSET = 8'b0010_0000,
    N_DIV    = 8'b0100_0000,
    N_DONE   = 8'b1000_0000
  } nstate_t;

  nstate_t state;

  logic signed [SW-1:0] s0, s1, s2;
  logic [SW-1:0]        mg0, mg1, mg2, mx, mg_sel;
  logic [41:0]          sq0, sq1, sq2;
  logic [63:0]          sq_x, sq_r, sq_one, sq_try;
  logic [46:0]          rem, num;
  logic [48:0]          dvs;
  logic [17:0]          quo, quo_next;
  logic [4:0]           step;
  logic [1:0]           comp;
  logic signed [SW-1:0] s_sel;
  logic [19:0]          a_mag;
  logic [31:0]          m_root;
  comp_t                rx, ry, rz, sat;
  logic                 take;

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    mag = v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  function automatic logic signed [SW-1:0] halve(input logic signed [SW-1:0] v);
    logic [SW-1:0] h;
    h = mag(v) >> 1;
    halve = v[SW-1] ? -$signed(h) : $signed(h);
  endfunction

  assign mg0 = mag(s0);
  assign mg1 = mag(s1);
  assign mg2 = mag(s2);

  always_comb begin
    mx = mg0;
    if (mg1 > mx) mx = mg1;
    if (mg2 > mx) mx = mg2;
  end

  always_comb begin
    case (comp)
      2'd0:    s_sel = s0;
      2'd1:    s_sel = s1;
      default: s_sel = s2;
    endcase
  end

  assign mg_sel = mag(s_sel);
  assign a_mag  = mg_sel[19:0];
  assign m_root = sq_r[31:0];
  assign num    = {2'b0, a_mag, 25'b0} + 47'(m_root >> 1);
  assign sq_try = sq_r + sq_one;

  assign take     = {2'b0, rem} >= dvs;
  assign quo_next = {quo[16:0], take};

  // round-half-up quotient, saturated to q1.15
  always_comb begin
    if (s_sel[SW-1]) begin
      sat = (quo_next >= 18'd32768) ? comp_t'(16'sh8000)
                                    : comp_t'(-$signed({1'b0, quo_next[14:0]}));
    end else begin
      sat = (quo_next >= 18'd32767) ? comp_t'(16'sd32767)
                                    : comp_t'({1'b0, quo_next[14:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      case (state)
        N_IDLE: begin
          if (start) begin
            s0 <= sum_x;
            s1 <= sum_y;
            s2 <= sum_z;
            if (sum_x == '0 && sum_y == '0 && sum_z == '0) begin
              rx    <= seed.x;
              ry    <= seed.y;
              rz    <= seed.z;
              state <= N_DONE;
            end else begin
              state <= N_SCALE;
            end
          end
        end
        N_SCALE: begin
          if (mx >= (SW'(1) << 20)) begin
            s0 <= halve(s0);
            s1 <= halve(s1);
            s2 <= halve(s2);
          end else if (mx < (SW'(1) << 19)) begin
            s0 <= s0 <<< 1;
            s1 <= s1 <<< 1;
            s2 <= s2 <<< 1;
          end else begin
            state <= N_SQ;
          end
        end
        N_SQ: begin
          sq0   <= 42'($signed(s0[20:0]) * $signed(s0[20:0]));
          sq1   <= 42'($signed(s1[20:0]) * $signed(s1[20:0]));
          sq2   <= 42'($signed(s2[20:0]) * $signed(s2[20:0]));
          state <= N_SUMQ;
        end
        N_SUMQ: begin
          sq_x   <= {2'b0, sq0 + sq1 + sq2, 20'b0};
          sq_r   <= '0;
          sq_one <= 64'd1 << 62;
          state  <= N_SQRT;
        end
        N_SQRT: begin
          if (sq_x >= sq_try) begin
            sq_x <= sq_x - sq_try;
            sq_r <= (sq_r >> 1) + sq_one;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_one <= sq_one >> 2;
          if (sq_one[0]) begin
            comp  <= 2'd0;
            state <= N_DIVSET;
          end
        end
        N_DIVSET: begin
          rem   <= num;
          dvs   <= {m_root, 17'b0};
          quo   <= '0;
          step  <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          if (take) rem <= rem - dvs[46:0];
          dvs  <= dvs >> 1;
          quo  <= quo_next;
          step <= step + 5'd1;
          if (step == 5'd17) begin
            case (comp)
              2'd0:    rx <= sat;
              2'd1:    ry <= sat;
              default: rz <= sat;
            endcase
            if (comp == 2'd2) begin
              state <= N_DONE;
            end else begin
              comp  <= comp + 2'd1;
              state <= N_DIVSET;
            end
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign res = '{done: (state == N_DONE), x: rx, y: ry, z: rz};

endmodule
`default_nettype wire

// ----- tb/cnwp_checker.sv -----
// checker for the curve window partitioner: predicts windows and compares results
`default_nettype none
module cnwp_checker import cnwp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic signed [COMP_W-1:0] normal_x,
  input  wire logic signed [COMP_W-1:0] normal_y,
  input  wire logic signed [COMP_W-1:0] normal_z,
  input  wire logic [LEN_W-1:0]        arc_length,
  input  wire logic                    last_point,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    result_valid,
  input  wire logic [RANGE_W-1:0]      range_start,
  input  wire logic [RANGE_W-1:0]      range_end,
  input  wire logic signed [COMP_W-1:0] dom_x,
  input  wire logic signed [COMP_W-1:0] dom_y,
  input  wire logic signed [COMP_W-1:0] dom_z,
  input  wire logic                    capped,
  input  wire logic                    ok,
  input  wire logic                    last_range,
  output int                           mismatches,
  output int                           outstanding
);

  typedef struct packed {
    logic [RANGE_W-1:0] first;
    logic [RANGE_W-1:0] last;
    comp_t              x;
    comp_t              y;
    comp_t              z;
    logic               cap;
    logic               good;
    logic               fin;
  } window_t;

  window_t windows_due[$];

  longint       samp[MAX_POINTS_DEF][3];
  longint       arc[MAX_POINTS_DEF];
  int           n_pts;
  bit           overflowed;
  longint       turn_c, break_c;
  longint       min_len;
  int           frames;
  bit           lengths_on;

  assign outstanding = windows_due.size();

  function automatic longint dot(int a, int b);
    return samp[a][0] * samp[b][0] + samp[a][1] * samp[b][1] + samp[a][2] * samp[b][2];
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // clustered mean normal of samples first..last
  function automatic vec_t cluster_mean(int first, int last);
    longint    nr[3], fr[3], s[3], mx, q, h;
    int        cn, cf;
    bit [63:0] m, a, v;
    vec_t      res;
    nr = '{0, 0, 0};
    fr = '{0, 0, 0};
    cn = 0;
    cf = 0;
    for (int i = first; i <= last; i++) begin
      if (dot(i, first) * 10 > NEAR_LIM) begin
        for (int k = 0; k < 3; k++) nr[k] += samp[i][k];
        cn++;
      end else begin
        for (int k = 0; k < 3; k++) fr[k] += samp[i][k];
        cf++;
      end
    end
    for (int k = 0; k < 3; k++) s[k] = (cn >= cf) ? nr[k] : fr[k];
    if (s[0] == 0 && s[1] == 0 && s[2] == 0) begin
      res.x = comp_t'(samp[first][0]);
      res.y = comp_t'(samp[first][1]);
      res.z = comp_t'(samp[first][2]);
      return res;
    end
    forever begin
      mx = mag(s[0]);
      if (mag(s[1]) > mx) mx = mag(s[1]);
      if (mag(s[2]) > mx) mx = mag(s[2]);
      if (mx >= (64'sd1 << 20)) begin
        for (int k = 0; k < 3; k++) begin
          h = mag(s[k]) / 2;
          s[k] = s[k] < 0 ? -h : h;
        end
      end else if (mx < (64'sd1 << 19)) begin
        for (int k = 0; k < 3; k++) s[k] = s[k] * 2;
      end else begin
        break;
      end
    end
    q = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
    m = int_sqrt(64'(q) << 20);
    if (m == 0) m = 1;
    for (int k = 0; k < 3; k++) begin
      a = 64'(mag(s[k]));
      v = ((a << 25) + m / 2) / m;
      if (s[k] < 0) h = (v >= 32768) ? -32768 : -longint'(v);
      else h = (v >= 32767) ? 32767 : longint'(v);
      if (k == 0) res.x = comp_t'(h);
      else if (k == 1) res.y = comp_t'(h);
      else res.z = comp_t'(h);
    end
    return res;
  endfunction

  // cut the stored curve into windows and queue their results
  task automatic predict_windows();
    window_t w;
    window_t found[$];
    vec_t    dn;
    int      first, last, lim;
    longint  d, span;
    bit      hit_limit;
    if (n_pts < 2) begin
      w = '0;
      w.cap = overflowed;
      w.fin = 1'b1;
      windows_due.push_back(w);
      return;
    end
    lim = frames > MAX_WINDOWS_DEF ? MAX_WINDOWS_DEF : frames;
    first = 0;
    hit_limit = 0;
    while (first < n_pts - 1) begin
      last = first + 1;
      while (last < n_pts - 1) begin
        d = dot(last, first);
        if (d < break_c) break;
        span = lengths_on ? arc[last] - arc[first] : 0;
        if (d < turn_c && span >= min_len) break;
        last++;
      end
      if (found.size() + 1 >= lim && last < n_pts - 1) begin
        hit_limit = 1;
        last = n_pts - 1;
      end
      dn = cluster_mean(first, last);
      w = '0;
      w.first = first[RANGE_W-1:0];
      w.last = last[RANGE_W-1:0];
      w.x = dn.x;
      w.y = dn.y;
      w.z = dn.z;
      w.good = 1'b1;
      found.push_back(w);
      if (last >= n_pts - 1) break;
      if (dot(last, first) < break_c) first = last;
      else first = ((first + last) / 2 > first + 1) ? (first + last) / 2 : first + 1;
    end
    foreach (found[i]) begin
      found[i].cap = hit_limit || overflowed;
      found[i].fin = (i == found.size() - 1);
      windows_due.push_back(found[i]);
    end
  endtask

  task automatic note_mismatch(string what, window_t exp_w, window_t got_w);
    if (mismatches < 10)
      $display("mismatch %s: expected %p, got %p", what, exp_w, got_w);
    mismatches++;
  endtask

  always @(posedge clk) begin
    window_t got_w;
    if (rst) begin
      windows_due.delete();
      mismatches = 0;
      n_pts = 0;
      overflowed = 0;
      turn_c = longint'(TURN_COS_RST) * 32768;
      break_c = longint'(BREAK_COS_RST) * 32768;
      min_len = MIN_LEN_RST;
      frames = FRAMES_RST;
      lengths_on = HAVE_LEN_RST;
    end else begin
      if (result_valid) begin
        got_w = {range_start, range_end, dom_x, dom_y, dom_z, capped, ok, last_range};
        if (windows_due.size() == 0) note_mismatch("unexpected result", '0, got_w);
        else if (windows_due[0] !== got_w) note_mismatch("window", windows_due[0], got_w);
        if (windows_due.size() != 0) void'(windows_due.pop_front());
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TURN_COS:   turn_c = longint'($signed(cfg_data[15:0])) * 32768;
          REG_BREAK_COS:  break_c = longint'($signed(cfg_data[15:0])) * 32768;
          REG_MIN_LENGTH: min_len = cfg_data;
          REG_MAX_FRAMES: frames = cfg_data[FRAMES_W-1:0];
          REG_HAVE_LEN:   lengths_on = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (n_pts < MAX_POINTS_DEF) begin
          samp[n_pts][0] = normal_x;
          samp[n_pts][1] = normal_y;
          samp[n_pts][2] = normal_z;
          arc[n_pts] = arc_length;
          n_pts++;
        end else begin
          overflowed = 1;
        end
        if (last_point) begin
          predict_windows();
          n_pts = 0;
          overflowed = 0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_curve_normal_window_partition.sv -----
// testbench top: drives curves and register settings, gives the verdict
`default_nettype none
module tb_curve_normal_window_partition;
  import cnwp_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [COMP_W-1:0] normal_x, normal_y, normal_z;
  logic [LEN_W-1:0]        arc_length;
  logic                    last_point;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    result_valid;
  logic [RANGE_W-1:0]      range_start, range_end;
  logic signed [COMP_W-1:0] dom_x, dom_y, dom_z;
  logic                    capped, ok, last_range;
  int                      mismatches;
  int                      outstanding;

  // running state of the curve being generated
  int                      dir_x, dir_y, dir_z;
  logic [LEN_W-1:0]        arc_acc;
  int                      sent;

  curve_normal_window_partition u_top (.*);

  cnwp_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // a generous ceiling, far above the slowest legal run
  initial begin
    #(12 * 4000000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int clamp16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  // one request: held until the block takes it at a rising edge
  task automatic send_sample(int x, int y, int z, logic [LEN_W-1:0] len, bit fin);
    @(negedge clk);
    start <= 1'b1;
    normal_x <= x[15:0];
    normal_y <= y[15:0];
    normal_z <= z[15:0];
    arc_length <= len;
    last_point <= fin;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sent++;
  endtask

  // idle gap on the command side: mostly short, now and then long
  task automatic maybe_gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // wait until every queued window has come back and the block is quiet
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int tc, int bc, logic [31:0] ml, int mf, bit hl);
    write_reg(REG_TURN_COS, 32'(tc));
    write_reg(REG_BREAK_COS, 32'(bc));
    write_reg(REG_MIN_LENGTH, ml);
    write_reg(REG_MAX_FRAMES, 32'(mf));
    write_reg(REG_HAVE_LEN, 32'(hl));
  endtask

  // fresh direction: an axis at full scale or anything at all
  task automatic pick_direction();
    int a;
    if ($urandom_range(0, 1)) begin
      dir_x = 0;
      dir_y = 0;
      dir_z = 0;
      a = $urandom_range(0, 5);
      case (a % 3)
        0: dir_x = (a < 3) ? 32767 : -32768;
        1: dir_y = (a < 3) ? 32767 : -32768;
        default: dir_z = (a < 3) ? 32767 : -32768;
      endcase
    end else begin
      dir_x = $signed(16'($urandom));
      dir_y = $signed(16'($urandom));
      dir_z = $signed(16'($urandom));
    end
  endtask

  // a curve of npts samples: drifting normals with occasional hard breaks,
  // or pure noise when noisy is set
  task automatic send_curve(int npts, bit noisy);
    int r, step;
    arc_acc = $urandom_range(0, 1) ? 32'd0 : $urandom;
    pick_direction();
    for (int i = 0; i < npts; i++) begin
      r = $urandom_range(0, 99);
      if (noisy) begin
        pick_direction();
      end else if (r < 8) begin
        pick_direction();
      end else begin
        step = (r < 40) ? 6000 : 1500;
        dir_x = clamp16(dir_x + $urandom_range(0, 2 * step) - step);
        dir_y = clamp16(dir_y + $urandom_range(0, 2 * step) - step);
        dir_z = clamp16(dir_z + $urandom_range(0, 2 * step) - step);
      end
      // arc length mostly grows, sometimes jumps anywhere
      if ($urandom_range(0, 19) == 0) arc_acc = $urandom;
      else arc_acc = arc_acc + $urandom_range(0, 90000);
      send_sample(dir_x, dir_y, dir_z, arc_acc, i == npts - 1);
      maybe_gap();
    end
  endtask

  initial begin
    int n;
    rst = 1'b1;
    start = 1'b0;
    normal_x = '0;
    normal_y = '0;
    normal_z = '0;
    arc_length = '0;
    last_point = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TURN_COS;
    cfg_data = '0;
    sent = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // --- directed part, register defaults ---
    // a single-sample curve is too short
    send_sample(32767, 0, 0, 32'd0, 1);
    drain();
    // two samples at the extremes of every field
    send_sample(-32768, -32768, -32768, 32'd0, 0);
    send_sample(32767, 32767, 32767, 32'hFFFF_FFFF, 1);
    drain();
    // alternating opposite normals: hard breaks between them
    send_sample(0, 0, 32767, 32'd0, 0);
    send_sample(0, 0, -32767, 32'd100, 0);
    send_sample(0, 0, 32767, 32'd200, 0);
    send_sample(0, 0, -32767, 32'd300, 1);
    drain();
    // zero normals everywhere
    send_sample(0, 0, 0, 32'd5, 0);
    send_sample(0, 0, 0, 32'd6, 0);
    send_sample(0, 0, 0, 32'd7, 1);
    drain();
    // hard break then gradual turn
    send_sample(32767, 0, 0, 32'd0, 0);
    send_sample(32767, 0, 0, 32'd65536, 0);
    send_sample(0, 32767, 0, 32'd131072, 0);
    send_sample(0, 30000, 13000, 32'd196608, 0);
    send_sample(0, 26000, 20000, 32'd262144, 0);
    send_sample(0, 20000, 26000, 32'd327680, 1);
    drain();

    // single-window limit with lengths off and no turns allowed
    set_regs(-32768, -32768, 32'hFFFF_FFFF, 1, 0);
    send_curve(12, 0);
    drain();
    // every turn splits, window limit at its top
    set_regs(32767, -32768, 32'd0, 64, 1);
    send_curve(20, 0);
    drain();
    // window limit of zero acts as one
    set_regs(28378, 16384, 32'd0, 0, 1);
    send_curve(9, 0);
    drain();
    // large window length threshold
    set_regs(30000, 0, 32'd200000, 8, 1);
    send_curve(16, 0);
    drain();

    // --- random part: mostly well-formed curves, some noise ---
    while (sent < 260) begin
      if ($urandom_range(0, 3) == 0) begin
        set_regs($urandom_range(0, 3) == 0 ? $signed(16'($urandom)) : $urandom_range(20000, 32767),
                 $urandom_range(0, 3) == 0 ? $signed(16'($urandom)) : $urandom_range(0, 24000),
                 $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 400000),
                 $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 12),
                 $urandom_range(0, 4) != 0);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
      send_curve(n, $urandom_range(0, 6) == 0);
      drain();
    end

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+src
src/cnwp_pkg.sv
src/cnwp_ram.sv
src/cnwp_dot.sv
src/cnwp_norm.sv
src/curve_normal_window_partition.sv
tb/cnwp_checker.sv
tb/tb_curve_normal_window_partition.sv
